// File: src/assert_macros.svh
// Assertion helpers, clocked on the rising edge and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Plain invariant checked at every clock edge
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error(msg);

`endif

// File: src/kfs_pkg.sv
package kfs_pkg;

   localparam int BYTE_W = 8;
   localparam int CNT_W  = 9;
   localparam int OUT_DEPTH = 4;

   // format byte codes
   localparam logic [BYTE_W-1:0] HDR_LEN4_A  = 8'h80;
   localparam logic [BYTE_W-1:0] HDR_LEN4_B  = 8'hC0;
   localparam logic [BYTE_W-1:0] HDR_SINGLE  = 8'hCC;
   localparam logic [BYTE_W-1:0] HI_MASK     = 8'hF0;
   localparam logic [BYTE_W-1:0] LO_MASK     = 8'h0F;

   localparam logic [CNT_W-1:0] LEN_POS      = 9'd4;  // position of the length byte
   localparam logic [CNT_W-1:0] LEN_EXTRA    = 9'd4;
   localparam logic [CNT_W-1:0] NIBBLE_EXTRA = 9'd3;

   typedef struct packed {
      logic [BYTE_W-1:0] line_byte;
      logic              is_checksum;
      logic              frame_end;
      logic              bad_header;
   } result_type;

   typedef struct packed {
      logic       first_valid;
      logic       second_valid;
      result_type first;
      result_type second;
   } push_type;

endpackage

// File: src/kfs_frame_ctrl.sv
module kfs_frame_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         item_valid,
   input  logic [kfs_pkg::BYTE_W-1:0]   item_byte,
   output kfs_pkg::push_type            push
);

   logic                        in_frame_ff, in_frame_in;
   logic [kfs_pkg::CNT_W-1:0]   taken_ff, taken_in;
   logic [kfs_pkg::CNT_W-1:0]   send_ff, send_in;
   logic                        len4_ff, len4_in;
   logic [kfs_pkg::BYTE_W-1:0]  sum_ff, sum_in;

   logic [kfs_pkg::BYTE_W-1:0]  hi_nib;
   logic [kfs_pkg::BYTE_W-1:0]  sum_next;
   logic [kfs_pkg::CNT_W-1:0]   taken_next;
   logic [kfs_pkg::CNT_W-1:0]   send_eff;
   kfs_pkg::push_type           push_raw;

   assign hi_nib     = item_byte & kfs_pkg::HI_MASK;
   assign sum_next   = sum_ff + item_byte;
   assign taken_next = taken_ff + kfs_pkg::CNT_W'(1);
   // the fourth byte of a long-form frame carries the length
   assign send_eff   = (len4_ff && taken_next == kfs_pkg::LEN_POS) ?
                       ({1'b0, item_byte} + kfs_pkg::LEN_EXTRA) : send_ff;

   always_comb begin
      push_raw    = '0;
      in_frame_in = in_frame_ff;
      taken_in    = taken_ff;
      send_in     = send_ff;
      len4_in     = len4_ff;
      sum_in      = sum_ff;
      if (!in_frame_ff) begin
         if (item_byte == kfs_pkg::HDR_LEN4_A || item_byte == kfs_pkg::HDR_LEN4_B) begin
            in_frame_in = 1'b1;
            len4_in     = 1'b1;
            send_in     = kfs_pkg::LEN_EXTRA;
            taken_in    = kfs_pkg::CNT_W'(1);
            sum_in      = item_byte;
            push_raw.first_valid     = 1'b1;
            push_raw.first.line_byte = item_byte;
         end else if (item_byte == kfs_pkg::HDR_SINGLE) begin
            push_raw.first_valid       = 1'b1;
            push_raw.first.line_byte   = kfs_pkg::HDR_SINGLE;
            push_raw.first.is_checksum = 1'b1;
            push_raw.first.frame_end   = 1'b1;
         end else if (hi_nib == kfs_pkg::HDR_LEN4_A || hi_nib == kfs_pkg::HDR_LEN4_B) begin
            in_frame_in = 1'b1;
            len4_in     = 1'b0;
            send_in     = kfs_pkg::CNT_W'(item_byte & kfs_pkg::LO_MASK)
                          + kfs_pkg::NIBBLE_EXTRA;
            taken_in    = kfs_pkg::CNT_W'(1);
            sum_in      = item_byte;
            push_raw.first_valid     = 1'b1;
            push_raw.first.line_byte = item_byte;
         end else begin
            push_raw.first_valid      = 1'b1;
            push_raw.first.bad_header = 1'b1;
         end
      end else begin
         push_raw.first_valid     = 1'b1;
         push_raw.first.line_byte = item_byte;
         if (taken_next >= send_eff) begin
            push_raw.second_valid       = 1'b1;
            push_raw.second.line_byte   = sum_next;
            push_raw.second.is_checksum = 1'b1;
            push_raw.second.frame_end   = 1'b1;
            in_frame_in = 1'b0;
            taken_in    = '0;
            send_in     = '0;
            len4_in     = 1'b0;
            sum_in      = '0;
         end else begin
            taken_in = taken_next;
            send_in  = send_eff;
            sum_in   = sum_next;
         end
      end
   end

   always_comb begin
      push              = push_raw;
      push.first_valid  = push_raw.first_valid && item_valid;
      push.second_valid = push_raw.second_valid && item_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         taken_ff    <= '0;
         send_ff     <= '0;
         len4_ff     <= 1'b0;
         sum_ff      <= '0;
      end else if (item_valid) begin
         in_frame_ff <= in_frame_in;
         taken_ff    <= taken_in;
         send_ff     <= send_in;
         len4_ff     <= len4_in;
         sum_ff      <= sum_in;
      end
   end

endmodule

// File: src/kfs_out_fifo.sv
module kfs_out_fifo #(
   parameter int Depth = kfs_pkg::OUT_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  kfs_pkg::push_type   push,
   output logic                room,       // space for two more words
   output logic                out_valid,
   input  logic                out_ready,
   output kfs_pkg::result_type out_word,
   output logic [$clog2(Depth+1)-1:0] level
);

   localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CW = $clog2(Depth+1);

   kfs_pkg::result_type entries_ff [Depth];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PW-1:0] wr_next1, wr_next2, rd_next;
   logic [CW-1:0] count_ff, count_in;
   logic          pop;

   assign wr_next1 = (wr_ff == PW'(Depth-1)) ? '0 : wr_ff + PW'(1);
   assign wr_next2 = (wr_next1 == PW'(Depth-1)) ? '0 : wr_next1 + PW'(1);
   assign rd_next  = (rd_ff == PW'(Depth-1)) ? '0 : rd_ff + PW'(1);

   assign out_valid = (count_ff != '0);
   assign out_word  = entries_ff[rd_ff];
   assign pop       = out_valid && out_ready;
   assign room      = (count_ff <= CW'(Depth-2));
   assign level     = count_ff;

   always_comb begin
      wr_in    = push.second_valid ? wr_next2 : (push.first_valid ? wr_next1 : wr_ff);
      rd_in    = pop ? rd_next : rd_ff;
      count_in = count_ff + CW'(push.first_valid) + CW'(push.second_valid) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         entries_ff[wr_ff] <= push.first;
      end
      if (push.second_valid) begin
         entries_ff[wr_next1] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

// File: src/kwp2000_frame_sender.sv
// An accepted byte waits in the input register until the result queue has room, is then written
// to the queue, and its word is then presented at rsp.
// Throughput: one byte per cycle while the result queue has room; the frame's final byte adds a
// checksum word, so under steady traffic the input stalls on each frame once the queue has filled.
// Reset (synchronous, active high) returns to waiting for a header and empties the queue.
`include "assert_macros.svh"

module kwp2000_frame_sender #(
   parameter int OutDepth = kfs_pkg::OUT_DEPTH   // at least 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] message_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] line_byte
   output logic [1:0] rsp_tuser,   // [0] is_checksum, [1] bad_header
   output logic       rsp_tlast    // frame_end
);

   logic                          in_valid_ff, in_valid_in;
   logic [kfs_pkg::BYTE_W-1:0]    in_byte_ff;
   logic                          room;
   logic                          take;
   kfs_pkg::push_type             push;
   kfs_pkg::result_type           head;
   logic [$clog2(OutDepth+1)-1:0] level;

   assign take        = in_valid_ff && room;
   assign req_tready  = !in_valid_ff || room;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !room);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   kfs_frame_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .item_valid (take),
      .item_byte  (in_byte_ff),
      .push       (push)
   );

   kfs_out_fifo #(
      .Depth (OutDepth)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_word  (head),
      .level     (level)
   );

   assign rsp_tdata = head.line_byte;
   assign rsp_tuser = {head.bad_header, head.is_checksum};
   assign rsp_tlast = head.frame_end;

   `ASSERT_ALWAYS(a_level_in_range, clock, reset, level <= ($clog2(OutDepth+1))'(OutDepth), "result queue overflow")
   `ASSERT_IMPL(a_second_needs_first, clock, reset, push.second_valid, push.first_valid && push.second.is_checksum, "checksum word pushed without its byte")
   `ASSERT_IMPL(a_push_only_on_take, clock, reset, !take, !push.first_valid, "word pushed with no byte taken")
   `ASSERT_IMPL(a_bad_no_end, clock, reset, rsp_tvalid && rsp_tuser[1], !rsp_tlast && !rsp_tuser[0], "rejected header word marked as frame end")

endmodule

// File: sim/kwp2000_frame_sender_tb.sv
`timescale 1ns / 100ps

module kwp2000_frame_sender_tb;

   localparam int STALL_LIMIT = 2000;   // cycles with no word moving on either side
   localparam int TOTAL_BYTES = 1350;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = '0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic       rsp_tlast;

   kwp2000_frame_sender uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // framer state as the block should hold it
   logic                      trk_in_frame = 1'b0;
   logic [kfs_pkg::CNT_W-1:0] trk_taken = '0;
   logic [kfs_pkg::CNT_W-1:0] trk_to_send = '0;
   logic                      trk_len_from_fourth = 1'b0;
   logic [7:0]                trk_sum = '0;

   kfs_pkg::result_type pending_line_words[$];
   int         mismatch_count = 0;
   int         bytes_sent = 0;
   int         idle_cycles = 0;

   // idling control shared by the stimulus and the receiver
   bit quiet = 1'b0;
   int hold_len = 0;
   int hold_seq = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int ready_run = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int idle_span();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 25);
   endfunction

   function automatic logic [7:0] payload_byte();
      int r;
      r = $urandom_range(0, 15);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   // expected line words for one accepted message byte
   task automatic frame_track(input logic [7:0] b);
      kfs_pkg::result_type w;
      w = '0;
      if (!trk_in_frame) begin
         if (b == kfs_pkg::HDR_LEN4_A || b == kfs_pkg::HDR_LEN4_B) begin
            trk_len_from_fourth = 1'b1;
            trk_to_send = kfs_pkg::LEN_POS;
         end else if (b == kfs_pkg::HDR_SINGLE) begin
            w.line_byte = b;
            w.is_checksum = 1'b1;
            w.frame_end = 1'b1;
         end else if ((b & kfs_pkg::HI_MASK) == kfs_pkg::HDR_LEN4_A ||
                      (b & kfs_pkg::HI_MASK) == kfs_pkg::HDR_LEN4_B) begin
            trk_len_from_fourth = 1'b0;
            trk_to_send = {1'b0, b & kfs_pkg::LO_MASK} + kfs_pkg::NIBBLE_EXTRA;
         end else begin
            w.bad_header = 1'b1;
         end
         if (b != kfs_pkg::HDR_SINGLE && !w.bad_header) begin
            trk_in_frame = 1'b1;
            trk_taken = 9'd1;
            trk_sum = b;
            w.line_byte = b;
         end
         pending_line_words.push_back(w);
      end else begin
         w.line_byte = b;
         pending_line_words.push_back(w);
         trk_sum = trk_sum + b;
         trk_taken = trk_taken + 9'd1;
         if (trk_len_from_fourth && trk_taken == kfs_pkg::LEN_POS)
            trk_to_send = {1'b0, b} + kfs_pkg::LEN_EXTRA;
         if (trk_taken >= trk_to_send) begin
            w = '0;
            w.line_byte = trk_sum;
            w.is_checksum = 1'b1;
            w.frame_end = 1'b1;
            pending_line_words.push_back(w);
            trk_in_frame = 1'b0;
            trk_taken = '0;
            trk_to_send = '0;
            trk_len_from_fourth = 1'b0;
            trk_sum = '0;
         end
      end
   endtask

   // valid is left high after the word so back-to-back words need no toggle
   task automatic send_message_byte(input logic [7:0] b);
      int gap;
      gap = idle_span();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      frame_track(b);
      bytes_sent++;
   endtask

   // whole frame for a header, assuming the block is waiting for a header
   task automatic send_frame(input logic [7:0] hdr, input logic [7:0] len_byte);
      int  total;
      bit  len_frame;
      len_frame = (hdr == kfs_pkg::HDR_LEN4_A || hdr == kfs_pkg::HDR_LEN4_B);
      if (len_frame)
         total = int'(len_byte) + 4;
      else if (hdr != kfs_pkg::HDR_SINGLE &&
               ((hdr & kfs_pkg::HI_MASK) == kfs_pkg::HDR_LEN4_A ||
                (hdr & kfs_pkg::HI_MASK) == kfs_pkg::HDR_LEN4_B))
         total = int'(hdr & kfs_pkg::LO_MASK) + 3;
      else
         total = 1;
      send_message_byte(hdr);
      for (int i = 2; i <= total; i++)
         send_message_byte((len_frame && i == 4) ? len_byte : payload_byte());
   endtask

   // the last word sent is withdrawn so it is not taken again while waiting
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_line_words.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed_formats();
      send_frame(8'h81, 8'h00);          // shortest nibble frame
      send_frame(8'h80, 8'h00);          // length byte of zero ends on the fourth byte
      send_frame(kfs_pkg::HDR_LEN4_B, 8'h01);
      send_frame(kfs_pkg::HDR_SINGLE, 8'h00);
      send_frame(8'hC1, 8'h00);
      send_frame(8'h00, 8'h00);
      send_frame(8'hFF, 8'h00);
      send_frame(8'h7F, 8'h00);
      send_frame(8'h90, 8'h00);
      send_frame(8'hBF, 8'h00);
      send_frame(8'hD0, 8'h00);
      send_frame(8'hF0, 8'h00);
   endtask

   // length bytes above 250 must not wrap the 9-bit count
   task automatic test_long_frames();
      send_frame(kfs_pkg::HDR_LEN4_B, 8'hFF);
      send_frame(kfs_pkg::HDR_LEN4_A, 8'd251);
   endtask

   task automatic test_output_backpressure();
      wait_drained();
      quiet = 1'b1;
      hold_len = 300;
      hold_seq++;
      send_frame(8'h8F, 8'h00);
      send_frame(kfs_pkg::HDR_SINGLE, 8'h00);
      send_frame(8'hC7, 8'h00);
      send_frame(8'h3C, 8'h00);
      quiet = 1'b0;
      wait_drained();
   endtask

   task automatic test_random_traffic(input int target);
      int         pick;
      logic [7:0] hdr;
      logic [7:0] len_byte;
      while (bytes_sent < target) begin
         if ($urandom_range(0, 149) == 0) quiet = !quiet;
         pick = $urandom_range(0, 99);
         len_byte = 8'($urandom_range(0, 12));
         if ($urandom_range(0, 9) == 0) len_byte = 8'($urandom_range(13, 40));
         if (pick < 50) begin
            hdr = {($urandom_range(0, 1) != 0) ? 4'hC : 4'h8, 4'($urandom_range(1, 15))};
            send_frame(hdr, len_byte);
         end else if (pick < 70) begin
            send_frame(($urandom_range(0, 1) != 0) ? kfs_pkg::HDR_LEN4_A : kfs_pkg::HDR_LEN4_B,
                       len_byte);
         end else if (pick < 78) begin
            send_frame(kfs_pkg::HDR_SINGLE, len_byte);
         end else if (pick < 95) begin
            send_frame(8'($urandom_range(0, 255)), len_byte);
         end else begin
            // loose bytes that may land mid-frame
            repeat ($urandom_range(1, 6)) send_message_byte(8'($urandom_range(0, 255)));
         end
      end
      quiet = 1'b0;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_formats();
      test_long_frames();
      test_output_backpressure();
      test_random_traffic(TOTAL_BYTES);
      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending_line_words.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // receiver: random stalls, none while quiet, and a long hold on request that applies even while quiet
   always @(posedge clock) begin : ready_gen
      int stall;
      if (hold_seen != hold_seq) begin
         hold_seen <= hold_seq;
         hold_left <= hold_len;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (quiet) begin
         rsp_tready <= 1'b1;
      end else if (ready_run != 0) begin
         ready_run <= ready_run - 1;
      end else if (rsp_tready) begin
         stall = idle_span();
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            ready_run <= stall - 1;
         end else begin
            ready_run <= $urandom_range(0, 10);
         end
      end else begin
         rsp_tready <= 1'b1;
         ready_run <= $urandom_range(0, 12);
      end
   end

   always @(posedge clock) begin : line_check
      kfs_pkg::result_type got;
      kfs_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.line_byte = rsp_tdata;
         got.is_checksum = rsp_tuser[0];
         got.bad_header = rsp_tuser[1];
         got.frame_end = rsp_tlast;
         if (pending_line_words.size() == 0) begin
            if (mismatch_count < 10)
               $display("%t unexpected word: byte %h chk %b end %b bad %b", $realtime,
                        got.line_byte, got.is_checksum, got.frame_end, got.bad_header);
            mismatch_count++;
         end else begin
            want = pending_line_words.pop_front();
            if (got.line_byte !== want.line_byte || got.is_checksum !== want.is_checksum ||
                got.frame_end !== want.frame_end || got.bad_header !== want.bad_header) begin
               if (mismatch_count < 10)
                  $display("%t want byte %h chk %b end %b bad %b, got byte %h chk %b end %b bad %b",
                           $realtime, want.line_byte, want.is_checksum, want.frame_end,
                           want.bad_header, got.line_byte, got.is_checksum, got.frame_end,
                           got.bad_header);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

endmodule

// File: filelist.f
+incdir+src
src/kfs_pkg.sv
src/kfs_frame_ctrl.sv
src/kfs_out_fifo.sv
src/kwp2000_frame_sender.sv
sim/kwp2000_frame_sender_tb.sv
